// ===== rtl/rpru_pkg.sv =====
// rpru_pkg: field widths, command codes, mode register bit positions and
// the patch lookup result type for the rom patch register unit
// no dependencies
package rpru_pkg;

	localparam int ADDR_W = 22;
	localparam int DATA_W = 16;
	localparam int CMD_W  = 2;

	// bus commands
	localparam logic [CMD_W-1:0] CMD_BYTE_WR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WORD_WR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WORD_RD = 2'd2;

	// mode register (register word 0) bit positions
	localparam int MODE_LOCK     = 8;
	localparam int MODE_READBACK = 9;
	localparam int MODE_CART     = 10;

	// slot zero is below 0x10000: address bits above this must be zero
	localparam int SLOT_LSB     = 16;
	// register readback window is below 0x40
	localparam int READBACK_LSB = 6;
	// register word index is address bits 5..1
	localparam int WIDX_W       = 5;
	// patch address high part keeps six bits
	localparam int PATCH_HI_W   = 6;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value;
	} match_t;

endpackage

// ===== rtl/rpru_req_if.sv =====
// rpru_req_if: request channel (valid, ready, bus access payload)
// depends on rpru_pkg
interface rpru_req_if
	import rpru_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic [DATA_W-1:0] cart_word;
	logic [DATA_W-1:0] genie_rom_word;

	modport source (output valid, cmd, address, write_data, cart_word, genie_rom_word,
		input ready);
	modport sink (input valid, cmd, address, write_data, cart_word, genie_rom_word,
		output ready);
endinterface

// ===== rtl/rpru_rsp_if.sv =====
// rpru_rsp_if: response channel (valid, ready, read data and status flags)
// depends on rpru_pkg
interface rpru_rsp_if
	import rpru_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              write_ignored;
	logic              substituted;

	modport source (output valid, read_data, write_ignored, substituted, input ready);
	modport sink (input valid, read_data, write_ignored, substituted, output ready);
endinterface

// ===== rtl/rpru_patch_match.sv =====
// rpru_patch_match: compares a read word address against the latched patch
// entries, lowest enabled entry wins; depends on rpru_pkg
module rpru_patch_match
	import rpru_pkg::*;
#(
	parameter int NUM_PATCHES = 6
) (
	input  logic [NUM_PATCHES-1:0]             enable,
	input  logic [NUM_PATCHES-1:0][ADDR_W-1:0] patch_addr,
	input  logic [NUM_PATCHES-1:0][DATA_W-1:0] patch_val,
	input  logic [ADDR_W-1:0]                  address,
	output match_t                             match
);

	logic [NUM_PATCHES-1:0] hit_vec;

	// word compare, bit 0 ignored on both sides
	always_comb begin
		for (int i = 0; i < NUM_PATCHES; i++) begin
			hit_vec[i] = enable[i] && (patch_addr[i][ADDR_W-1:1] == address[ADDR_W-1:1]);
		end
	end

	// highest index first so the lowest hit overrides
	always_comb begin
		match.hit   = 1'b0;
		match.value = '0;
		for (int i = NUM_PATCHES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				match.hit   = 1'b1;
				match.value = patch_val[i];
			end
		end
	end

endmodule

// ===== rtl/rom_patch_register_unit.sv =====
// rom_patch_register_unit: cartridge pass-through patch unit top level
// depends on rpru_pkg, rpru_req_if, rpru_rsp_if and rpru_patch_match
//
// usage
//   req carries one bus access per item: byte write, word write or word read,
//   with the cartridge and on-board rom words already fetched for its address.
//   rsp returns exactly one item per request item: read_data for reads (zero
//   for writes), write_ignored when a slot-zero write hit the lock, and
//   substituted when a cartridge read was answered from a patch entry.
//   throughput: one item per clock while rsp takes its items; the access is
//   done in a single pass of logic between the input register and the response
//   register, and the register file and patch entries update at the same edge,
//   so the next item already sees the new state.
//   path: an item goes from req acceptance to rsp valid through the input
//   register, then the response register.
//   stall: a stalled rsp holds its item; the input register still moves into
//   the response register in the cycle rsp.ready returns, so req.ready drops
//   only while both stages are full and rsp is not taken.
//   reset: arst_n clears both stages, the register file (mode register
//   included, so the unit comes up unlocked) and all patch entries.
//   writing the mode register with the lock bit latches the patch entries
//   and clears the enable of any entry that repeats an earlier address.
module rom_patch_register_unit
	import rpru_pkg::*;
#(
	parameter int NUM_PATCHES = 6,
	parameter int REG_COUNT   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	rpru_req_if.sink          req,
	rpru_rsp_if.source        rsp
);

	localparam int IDX_W = $clog2(REG_COUNT);

	// input register stage
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [DATA_W-1:0] cart_s1;
	logic [DATA_W-1:0] grom_s1;

	// response register
	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              write_ignored_q;
	logic              substituted_q;

	// state
	logic [DATA_W-1:0]                  regs_q [REG_COUNT];
	logic [NUM_PATCHES-1:0][ADDR_W-1:0] patch_addr_q;
	logic [NUM_PATCHES-1:0][DATA_W-1:0] patch_val_q;

	logic              advance;
	logic [DATA_W-1:0] mode;
	logic              locked;
	logic [WIDX_W-1:0] word_idx;
	logic              idx_ok;
	logic              in_slot;
	logic              in_readback;
	logic              is_write;
	logic [DATA_W-1:0] old_word;
	logic [DATA_W-1:0] merged;
	logic              do_write;
	logic              do_latch;
	logic [DATA_W-1:0] new_word;

	logic [NUM_PATCHES-1:0][ADDR_W-1:0] lat_addr;
	logic [NUM_PATCHES-1:0][DATA_W-1:0] lat_val;
	logic [NUM_PATCHES-1:0]             dup;
	logic [DATA_W-1:0]                  clr_mask;

	match_t            match;
	logic [DATA_W-1:0] cart_path;
	logic [DATA_W-1:0] rd_next;
	logic              ign_next;
	logic              sub_next;

	// handshake: input stage moves whenever the response register is free
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1   <= req.cmd;
			addr_s1  <= req.address;
			wdata_s1 <= req.write_data;
			cart_s1  <= req.cart_word;
			grom_s1  <= req.genie_rom_word;
		end
	end

	// decode of the access in the input stage
	assign mode        = regs_q[0];
	assign locked      = mode[MODE_LOCK];
	assign word_idx    = addr_s1[WIDX_W:1];
	assign idx_ok      = ({1'b0, word_idx} < (WIDX_W + 1)'(REG_COUNT));
	assign in_slot     = (addr_s1[ADDR_W-1:SLOT_LSB] == '0);
	assign in_readback = (addr_s1[SLOT_LSB-1:READBACK_LSB] == '0);
	assign is_write    = (cmd_s1 == CMD_BYTE_WR) || (cmd_s1 == CMD_WORD_WR);
	assign old_word    = idx_ok ? regs_q[word_idx[IDX_W-1:0]] : '0;

	// byte lane merge: even address writes the upper byte
	always_comb begin
		if (cmd_s1 == CMD_BYTE_WR) begin
			if (addr_s1[0]) begin
				merged = {old_word[DATA_W-1:8], wdata_s1[7:0]};
			end else begin
				merged = {wdata_s1[7:0], old_word[7:0]};
			end
		end else begin
			merged = wdata_s1;
		end
	end

	assign do_write = advance && is_write && in_slot && !locked && idx_ok;
	assign do_latch = do_write && (word_idx == '0) && merged[MODE_LOCK];

	// patch entry sources: registers 2+3i, 3+3i, 4+3i; past the bank reads zero
	for (genvar g = 0; g < NUM_PATCHES; g++) begin : g_src
		localparam int SRC_HI  = 2 + 3 * g;
		localparam int SRC_LO  = 3 + 3 * g;
		localparam int SRC_VAL = 4 + 3 * g;
		logic [DATA_W-1:0] hi_word;
		logic [DATA_W-1:0] lo_word;

		if (SRC_HI < REG_COUNT) begin : g_hi
			assign hi_word = regs_q[SRC_HI];
		end else begin : g_hi_zero
			assign hi_word = '0;
		end
		if (SRC_LO < REG_COUNT) begin : g_lo
			assign lo_word = regs_q[SRC_LO];
		end else begin : g_lo_zero
			assign lo_word = '0;
		end
		if (SRC_VAL < REG_COUNT) begin : g_val
			assign lat_val[g] = regs_q[SRC_VAL];
		end else begin : g_val_zero
			assign lat_val[g] = '0;
		end
		assign lat_addr[g] = {hi_word[PATCH_HI_W-1:0], lo_word};
	end

	// an entry repeating any earlier address loses its enable
	always_comb begin
		dup = '0;
		for (int i = 1; i < NUM_PATCHES; i++) begin
			for (int j = 0; j < i; j++) begin
				if (lat_addr[j] == lat_addr[i]) begin
					dup[i] = 1'b1;
				end
			end
		end
		clr_mask = '0;
		clr_mask[NUM_PATCHES-1:0] = dup;
	end

	assign new_word = do_latch ? (merged & ~clr_mask) : merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
			patch_addr_q <= '0;
			patch_val_q  <= '0;
		end else begin
			if (do_write) begin
				regs_q[word_idx[IDX_W-1:0]] <= new_word;
			end
			if (do_latch) begin
				patch_addr_q <= lat_addr;
				patch_val_q  <= lat_val;
			end
		end
	end

	// read-time patch compare, only while locked
	rpru_patch_match #(
		.NUM_PATCHES (NUM_PATCHES)
	) u_match (
		.enable     (mode[NUM_PATCHES-1:0] & {NUM_PATCHES{locked}}),
		.patch_addr (patch_addr_q),
		.patch_val  (patch_val_q),
		.address    (addr_s1),
		.match      (match)
	);

	assign cart_path = match.hit ? match.value : cart_s1;

	// result of the access
	always_comb begin
		rd_next  = '0;
		ign_next = 1'b0;
		sub_next = 1'b0;
		case (cmd_s1)
			CMD_BYTE_WR, CMD_WORD_WR: begin
				ign_next = in_slot && locked;
			end
			CMD_WORD_RD: begin
				if (!in_slot || mode[MODE_CART]) begin
					rd_next  = cart_path;
					sub_next = match.hit;
				end else if (mode[MODE_READBACK]) begin
					if (in_readback) begin
						rd_next = old_word;
					end else begin
						rd_next  = cart_path;
						sub_next = match.hit;
					end
				end else begin
					rd_next = grom_s1;
				end
			end
			default: begin
				rd_next = '0;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q     <= rd_next;
			write_ignored_q <= ign_next;
			substituted_q   <= sub_next;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_data     = read_data_q;
	assign rsp.write_ignored = write_ignored_q;
	assign rsp.substituted   = substituted_q;

endmodule

// ===== tb/sv/rom_patch_register_unit_test.sv =====
`timescale 1ns / 100ps
// rom_patch_register_unit_test: self-checking testbench for the rom patch register unit
// depends on rpru_pkg, rpru_req_if, rpru_rsp_if and rom_patch_register_unit
module rom_patch_register_unit_test;
	import rpru_pkg::*;

	localparam int NUM_PATCHES    = 6;
	localparam int REG_COUNT      = 32;
	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int OPEN_ITEMS     = 800;
	localparam int LOCKED_ITEMS   = 400;
	localparam int PHASE_ITEMS    = 420;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 100000;
	localparam int REPORT_MAX     = 10;
	localparam int MODE_REG       = 0;
	localparam int PATCH_REG_BASE = 2;
	localparam int ADDR_POOL      = 3;

	// the one command code that the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
		logic [DATA_W-1:0] cart_word;
		logic [DATA_W-1:0] genie_rom_word;
	} bus_access_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              write_ignored;
		logic              substituted;
	} bus_reply_t;

	// one directed row: typed marks an expectation written by hand
	typedef struct packed {
		bus_access_t acc;
		logic        typed;
		bus_reply_t  want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rpru_req_if req();
	rpru_rsp_if rsp();

	rom_patch_register_unit #(
		.NUM_PATCHES(NUM_PATCHES),
		.REG_COUNT(REG_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predictor state: register bank and the patch entries latched at lock time
	logic [DATA_W-1:0] shadow_regs [REG_COUNT];
	logic [ADDR_W-1:0] latched_addr [NUM_PATCHES];
	logic [DATA_W-1:0] latched_value [NUM_PATCHES];

	// stimulus side: patch targets planned for the lock step
	logic [ADDR_W-1:0] planned_addr [NUM_PATCHES];

	bus_reply_t    pending_replies [$];
	directed_row_t directed_rows [$];

	int mismatch_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int sender_idle_pct = 26;
	int receiver_stall_pct = 55;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// register read with the out-of-bank case reading as zero
	function automatic logic [DATA_W-1:0] reg_word(input int idx);
		return (idx < REG_COUNT) ? shadow_regs[idx] : '0;
	endfunction

	// lock step: capture every entry, then drop the enable of any entry whose
	// address repeats an earlier one, enabled or not
	task automatic latch_patch_entries();
		logic [DATA_W-1:0] hi;
		for (int i = 0; i < NUM_PATCHES; i++) begin
			hi = reg_word(PATCH_REG_BASE + 3 * i);
			latched_addr[i] = {hi[PATCH_HI_W-1:0], reg_word(PATCH_REG_BASE + 3 * i + 1)};
			latched_value[i] = reg_word(PATCH_REG_BASE + 3 * i + 2);
		end
		for (int i = 1; i < NUM_PATCHES; i++)
			for (int j = 0; j < i; j++)
				if (latched_addr[j] == latched_addr[i])
					shadow_regs[MODE_REG][i] = 1'b0;
	endtask

	// cartridge read, answered from a patch entry while locked; the scan runs
	// from the top so the lowest matching entry is the one that sticks
	task automatic cart_or_patch(input bus_access_t a, inout bus_reply_t r);
		r.read_data = a.cart_word;
		if (shadow_regs[MODE_REG][MODE_LOCK]) begin
			for (int i = NUM_PATCHES - 1; i >= 0; i--) begin
				if (shadow_regs[MODE_REG][i] &&
						latched_addr[i][ADDR_W-1:1] == a.address[ADDR_W-1:1]) begin
					r.read_data = latched_value[i];
					r.substituted = 1'b1;
				end
			end
		end
	endtask

	task automatic predict_bus_access(input bus_access_t a, output bus_reply_t r);
		int idx;
		logic in_slot;
		logic [DATA_W-1:0] mode;
		logic [DATA_W-1:0] v;
		r = '0;
		in_slot = (a.address[ADDR_W-1:SLOT_LSB] == '0);
		idx = a.address[WIDX_W:1];
		mode = shadow_regs[MODE_REG];
		case (a.cmd)
			CMD_BYTE_WR, CMD_WORD_WR: begin
				if (in_slot && mode[MODE_LOCK]) begin
					r.write_ignored = 1'b1;
				end else if (in_slot && idx < REG_COUNT) begin
					v = a.write_data;
					if (a.cmd == CMD_BYTE_WR) begin
						// even address takes the upper byte, odd the lower
						v = shadow_regs[idx];
						if (a.address[0])
							v[7:0] = a.write_data[7:0];
						else
							v[15:8] = a.write_data[7:0];
					end
					shadow_regs[idx] = v;
					if (idx == MODE_REG && v[MODE_LOCK])
						latch_patch_entries();
				end
			end
			CMD_WORD_RD: begin
				if (!in_slot || mode[MODE_CART]) begin
					cart_or_patch(a, r);
				end else if (mode[MODE_READBACK]) begin
					if (a.address[ADDR_W-1:READBACK_LSB] == '0)
						r.read_data = reg_word(idx);
					else
						cart_or_patch(a, r);
				end else begin
					// on-board rom is never patched
					r.read_data = a.genie_rom_word;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] address,
			input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] cart,
			input logic [DATA_W-1:0] grom, input logic typed,
			input logic [DATA_W-1:0] rd, input logic ign, input logic sub);
		directed_rows.push_back('{'{cmd, address, wdata, cart, grom}, typed, '{rd, ign, sub}});
	endtask

	// low register window, anywhere in slot zero, or out in cartridge space
	function automatic logic [ADDR_W-1:0] any_address();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4)
			return ADDR_W'($urandom_range(63));
		else if (pick < 7)
			return {{(ADDR_W - SLOT_LSB){1'b0}}, 16'($urandom)};
		else
			return {6'($urandom_range(1, 63)), 16'($urandom)};
	endfunction

	function automatic bus_access_t random_payload();
		bus_access_t a;
		a.cmd = CMD_WORD_RD;
		a.address = any_address();
		a.write_data = 16'($urandom);
		a.cart_word = 16'($urandom);
		a.genie_rom_word = 16'($urandom);
		return a;
	endfunction

	// unlocked traffic: register and mode writes, reads through every path,
	// out-of-slot writes and the unused command
	function automatic bus_access_t random_open_access();
		bus_access_t a;
		int pick;
		a = random_payload();
		pick = $urandom_range(99);
		if (pick < 15) begin
			// mode register, often through a mirror higher in slot zero
			a.cmd = $urandom_range(1) ? CMD_WORD_WR : CMD_BYTE_WR;
			a.address = {{(ADDR_W - SLOT_LSB){1'b0}}, 16'($urandom) & 16'hffc1};
		end else if (pick < 45) begin
			a.cmd = $urandom_range(1) ? CMD_WORD_WR : CMD_BYTE_WR;
			if ($urandom_range(9) < 7)
				a.address = ADDR_W'($urandom_range(63));
		end else if (pick < 55) begin
			a.cmd = $urandom_range(1) ? CMD_WORD_WR : CMD_BYTE_WR;
			a.address = {6'($urandom_range(1, 63)), 16'($urandom)};
		end else if (pick >= 95) begin
			a.cmd = CMD_UNUSED;
		end
		// keep the lock bit clear here, the lock is one-way until reset
		if (a.cmd != CMD_WORD_RD && a.cmd != CMD_UNUSED &&
				a.address[ADDR_W-1:SLOT_LSB] == '0 && a.address[WIDX_W:1] == MODE_REG) begin
			if (a.cmd == CMD_WORD_WR)
				a.write_data[MODE_LOCK] = 1'b0;
			else if (!a.address[0])
				a.write_data[MODE_LOCK - 8] = 1'b0;
		end
		return a;
	endfunction

	// locked traffic: mostly reads at the patch targets, with bit 0 flipped
	// half the time, plus near misses, writes that must be dropped and noise
	function automatic bus_access_t random_locked_access();
		bus_access_t a;
		int pick;
		int k;
		a = random_payload();
		pick = $urandom_range(99);
		k = $urandom_range(NUM_PATCHES - 1);
		if (pick < 60)
			a.address = planned_addr[k] ^ ADDR_W'($urandom_range(1));
		else if (pick < 70)
			a.address = planned_addr[k] ^ (ADDR_W'(1) << $urandom_range(1, ADDR_W - 1));
		else if (pick < 95 && pick >= 80)
			a.cmd = $urandom_range(1) ? CMD_WORD_WR : CMD_BYTE_WR;
		else if (pick >= 95)
			a.cmd = CMD_UNUSED;
		return a;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_access(input bus_access_t a, input logic typed, input bus_reply_t want);
		bus_reply_t predicted;
		// sender and receiver swap idling after the first phase, then both stop
		if (items_sent < PHASE_ITEMS) begin
			sender_idle_pct = 26;
			receiver_stall_pct = 55;
		end else if (items_sent < 2 * PHASE_ITEMS) begin
			sender_idle_pct = 55;
			receiver_stall_pct = 26;
		end else begin
			sender_idle_pct = 0;
			receiver_stall_pct = 0;
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.cmd = a.cmd;
		req.address = a.address;
		req.write_data = a.write_data;
		req.cart_word = a.cart_word;
		req.genie_rom_word = a.genie_rom_word;
		do @(posedge clk); while (!req.ready);
		predict_bus_access(a, predicted);
		pending_replies.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// register write as one word write or as a lower then upper byte pair,
	// at a random mirror of the register in slot zero
	task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
		bus_access_t a;
		a = random_payload();
		a.address = {{(ADDR_W - SLOT_LSB){1'b0}}, 10'($urandom), WIDX_W'(idx), 1'b0};
		if ($urandom_range(1)) begin
			a.cmd = CMD_WORD_WR;
			a.write_data = value;
			send_access(a, 1'b0, '0);
		end else begin
			a.cmd = CMD_BYTE_WR;
			a.address[0] = 1'b1;
			a.write_data = {8'($urandom), value[7:0]};
			send_access(a, 1'b0, '0);
			a.address[0] = 1'b0;
			a.write_data = {8'($urandom), value[15:8]};
			send_access(a, 1'b0, '0);
		end
	endtask

	// fill the patch registers from a small pool of targets so repeats are
	// common, then set the lock with random enables and read-path bits
	task automatic arm_patches();
		logic [ADDR_W-1:0] pool [ADDR_POOL];
		logic [DATA_W-1:0] mode;
		pool[0] = {{(ADDR_W - SLOT_LSB){1'b0}}, 16'($urandom)};
		for (int p = 1; p < ADDR_POOL; p++)
			pool[p] = ADDR_W'($urandom);
		for (int i = 0; i < NUM_PATCHES; i++) begin
			planned_addr[i] = pool[$urandom_range(ADDR_POOL - 1)];
			// upper bits of the high half are don't-care for the entry
			write_reg(PATCH_REG_BASE + 3 * i, {10'($urandom), planned_addr[i][ADDR_W-1:SLOT_LSB]});
			write_reg(PATCH_REG_BASE + 3 * i + 1, planned_addr[i][SLOT_LSB-1:0]);
			write_reg(PATCH_REG_BASE + 3 * i + 2, 16'($urandom));
		end
		mode = 16'($urandom);
		mode[MODE_LOCK] = 1'b1;
		write_reg(MODE_REG, mode);
	endtask

	// ------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready = ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic note_mismatch(input string field, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
	endtask

	always @(posedge clk) begin
		bus_reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_replies.size() == 0) begin
				note_mismatch("unrequested item", 0, rsp.read_data);
			end else begin
				want = pending_replies.pop_front();
				if (rsp.read_data !== want.read_data)
					note_mismatch("read_data", want.read_data, rsp.read_data);
				if (rsp.write_ignored !== want.write_ignored)
					note_mismatch("write_ignored", want.write_ignored, rsp.write_ignored);
				if (rsp.substituted !== want.substituted)
					note_mismatch("substituted", want.substituted, rsp.substituted);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		req.valid = 1'b0;
		req.cmd = CMD_WORD_RD;
		req.address = '0;
		req.write_data = '0;
		req.cart_word = '0;
		req.genie_rom_word = '0;
		for (int i = 0; i < REG_COUNT; i++)
			shadow_regs[i] = '0;
		for (int i = 0; i < NUM_PATCHES; i++) begin
			latched_addr[i] = '0;
			latched_value[i] = '0;
			planned_addr[i] = '0;
		end

		// directed rows; the lock is one-way until reset, so every row here
		// stays unlocked and the lock step comes after the open traffic
		// after reset the mode is zero, so slot-zero reads give the on-board rom
		add_row(CMD_WORD_RD, 22'h000000, 16'h0000, 16'h1234, 16'hbeef, 1'b1, 16'hbeef, 0, 0);
		// top of cartridge space is a plain cartridge read
		add_row(CMD_WORD_RD, 22'h3fffff, 16'h0000, 16'hffff, 16'h0000, 1'b1, 16'hffff, 0, 0);
		// unused command answers all zero
		add_row(CMD_UNUSED, 22'h3fffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, 16'h0000, 0, 0);
		// write outside slot zero whose low bits alias the mode register
		add_row(CMD_WORD_WR, 22'h3f0000, 16'hffff, 16'hffff, 16'hffff, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_WORD_WR, 22'h000002, 16'hffff, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		// byte lanes: even address fills the upper byte, odd the lower
		add_row(CMD_BYTE_WR, 22'h000004, 16'hffa5, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_BYTE_WR, 22'h000005, 16'h003c, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		// readback mode
		add_row(CMD_WORD_WR, 22'h000000, 16'h0200, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_WORD_RD, 22'h000004, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, 0, 0);
		add_row(CMD_WORD_RD, 22'h000001, 16'h0000, 16'hffff, 16'hffff, 1'b0, '0, 0, 0);
		add_row(CMD_WORD_RD, 22'h00003e, 16'h0000, 16'hffff, 16'hffff, 1'b0, '0, 0, 0);
		// first address past the readback window goes to the cartridge
		add_row(CMD_WORD_RD, 22'h000040, 16'h0000, 16'h0f0f, 16'hf0f0, 1'b0, '0, 0, 0);
		// top slot-zero word aliases the last register
		add_row(CMD_WORD_WR, 22'h00ffff, 16'h8001, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_WORD_RD, 22'h00003f, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0, 0, 0);
		// enables through the lower byte, cartridge bit through a mirror
		add_row(CMD_BYTE_WR, 22'h000001, 16'hff3f, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_BYTE_WR, 22'h000040, 16'h0004, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_WORD_RD, 22'h000002, 16'h0000, 16'ha5a5, 16'h5a5a, 1'b0, '0, 0, 0);
		add_row(CMD_WORD_WR, 22'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 0, 0);
		add_row(CMD_WORD_RD, 22'h00ffff, 16'h0000, 16'h0000, 16'hffff, 1'b0, '0, 0, 0);
		add_row(CMD_WORD_RD, 22'h010000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h8000, 0, 0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);

		for (int n = 0; n < OPEN_ITEMS; n++)
			send_access(random_open_access(), 1'b0, '0);

		arm_patches();

		for (int n = 0; n < LOCKED_ITEMS; n++)
			send_access(random_locked_access(), 1'b0, '0);

		req.valid = 1'b0;
		// the watchdog covers a reply that never arrives
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rpru_pkg.sv
rtl/rpru_req_if.sv
rtl/rpru_rsp_if.sv
rtl/rpru_patch_match.sv
rtl/rom_patch_register_unit.sv
tb/sv/rom_patch_register_unit_test.sv
